@@ rtl/tpt_pkg.sv @@
package tpt_pkg;

   localparam int MAX_POINTS_DEFAULT = 1024;
   localparam logic [31:0] MIN_STEP = 32'd655;
   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   typedef enum logic [1:0] {
      ACT_GENERATE   = 2'd0,
      ACT_QUERY_TIME = 2'd1,
      ACT_QUERY_DIST = 2'd2,
      ACT_NONE       = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_SHORT = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_MAX_VEL   = 2'd0,
      CSR_MAX_ACC   = 2'd1,
      CSR_MAX_DEC   = 2'd2,
      CSR_STEP      = 2'd3
   } csr_index_type;

   // command to the shared divide / square root unit
   typedef struct packed {
      logic start;
      logic root;
   } ds_cmd_type;

endpackage

@@ rtl/tpt_if.sv @@
interface tpt_req_if;
   import tpt_pkg::*;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] operand_value;

   modport source (output valid, output action, output operand_value, input ready);
   modport sink (input valid, input action, input operand_value, output ready);
endinterface

interface tpt_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] point_time;
   logic [31:0] point_position;
   logic [31:0] point_velocity;
   logic [10:0] point_count;
   logic [1:0]  status;

   modport source (output valid, output point_time, output point_position,
                   output point_velocity, output point_count, output status, input ready);
   modport sink (input valid, input point_time, input point_position,
                 input point_velocity, input point_count, input status, output ready);
endinterface

@@ rtl/tpt_divsqrt.sv @@
// Shared bit-serial unit: 64/33 restoring divide or
// 64-bit integer square root, one subtractor for both.
module tpt_divsqrt (
   input  logic                clock,
   input  logic                reset,
   input  tpt_pkg::ds_cmd_type cmd,
   input  logic [63:0]         operand_a,
   input  logic [32:0]         operand_b,
   output logic                done,
   output logic [63:0]         result
);
   import tpt_pkg::*;

   logic        busy_ff, busy_in;
   logic        root_ff, root_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] num_ff, num_in;
   logic [32:0] den_ff, den_in;
   logic [32:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic        done_ff, done_in;
   logic [35:0] trial_a, trial_b, diff;
   logic        ge;

   always_comb begin
      if (root_ff) begin
         trial_a = {1'b0, rem_ff, num_ff[63:62]};
         trial_b = {2'b0, quo_ff[31:0], 2'b01};
      end else begin
         trial_a = {2'b0, rem_ff, num_ff[63]};
         trial_b = {3'b0, den_ff};
      end
      diff = trial_a - trial_b;
      ge   = ~diff[35];
   end

   always_comb begin
      busy_in = busy_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         busy_in = 1'b1;
         root_in = cmd.root;
         cnt_in  = cmd.root ? 7'd31 : 7'd63;
         num_in  = operand_a;
         den_in  = operand_b;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[32:0] : trial_a[32:0];
         quo_in = {quo_ff[62:0], ge};
         num_in = root_ff ? {num_ff[61:0], 2'b00} : {num_ff[62:0], 1'b0};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         root_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         root_ff <= root_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done   = done_ff;
   assign result = quo_ff;
endmodule

@@ rtl/trapezoidal_profile_table.sv @@
// Generate: per table point, two multiplies, a square root and a divide on the
// shared unit; then each back point is moved into place and the time prefix
// sum is formed over the entries.
// Query: entries are scanned one by one, then the result is interpolated.
// One item at a time; ready only while idle. Synchronous active-high reset
// empties the table and restores the register defaults; no clearing pass.
module trapezoidal_profile_table #(
   parameter int MAX_POINTS = tpt_pkg::MAX_POINTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   tpt_req_if.sink     req_chan,
   tpt_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_write_data
);
   import tpt_pkg::*;

   localparam int IDXW = $clog2(MAX_POINTS);
   localparam int CNTW = $clog2(MAX_POINTS + 1);
   localparam logic [CNTW-1:0] TOP = CNTW'(MAX_POINTS - 1);
   localparam logic [CNTW-1:0] MAXC = CNTW'(MAX_POINTS);

   typedef enum logic [4:0] {
      S_IDLE, S_G_FRONT0, S_G_BACK0, S_G_TEST, S_SP_MUL1, S_SP_MUL2, S_SP_ROOT,
      S_SP_WAIT, S_SG_START, S_SG_WAIT, S_G_STORE, S_CP_RD, S_CP_WR, S_PF_RD,
      S_PF_WR, S_Q_RD, S_Q_TEST, S_L_MUL, S_L_DIV, S_L_WAIT, S_DONE
   } state_type;

   typedef enum logic [1:0] {PH_FRONT, PH_BACK, PH_JOIN} phase_type;

   logic [31:0] pos_mem [MAX_POINTS];
   logic [31:0] vel_mem [MAX_POINTS];
   logic [31:0] tim_mem [MAX_POINTS];

   state_type   state_ff;
   phase_type   phase_ff;
   logic [31:0] vmax_ff, acc_ff, dec_ff, step_ff;
   logic [CNTW-1:0] count_ff, nf_ff, nb_ff, idx_ff;
   logic [31:0] fpos_ff, fvel_ff, bpos_ff, bvel_ff, nvel_ff, seg_ff;
   logic [31:0] opnd_ff, sum_ff;
   action_type  act_ff;
   logic [63:0] prod_ff, sq_ff;
   logic [31:0] prev_t_ff, prev_p_ff, prev_v_ff, cur_t_ff, cur_p_ff, cur_v_ff;
   logic [31:0] lnum_ff, lden_ff;
   logic        lsel_ff;
   logic [31:0] res_t_ff, res_p_ff, res_v_ff;
   status_type  res_st_ff;
   logic        rsp_valid_ff;
   logic [31:0] rsp_t_ff, rsp_p_ff, rsp_v_ff;
   logic [10:0] rsp_cnt_ff;
   logic [1:0]  rsp_st_ff;

   logic [31:0] rd_p, rd_v, rd_t;
   logic [IDXW-1:0] ra, wa_pv, wa_t;
   logic        we_p, we_v, we_t;
   logic [31:0] wd_p, wd_v, wd_t;

   logic [31:0] mul_a, mul_b;
   ds_cmd_type  ds_cmd;
   logic [63:0] ds_a;
   logic [32:0] ds_b;
   logic        ds_done;
   logic [63:0] ds_res;

   logic [63:0] two_ar, rad;
   logic [64:0] rad_sum;
   logic [31:0] root_clamped;
   logic [32:0] seg_den;
   logic [31:0] seg_old;
   logic [31:0] key, kprev, y0, y1, ydiff, lerp_val;
   logic [32:0] psum;
   logic [31:0] fpos_next, bpos_next;

   function automatic logic [IDXW-1:0] top_idx(input logic [CNTW-1:0] k);
      logic [CNTW-1:0] t;
      t = TOP - k;
      return t[IDXW-1:0];
   endfunction

   tpt_divsqrt u_ds (
      .clock     (clock),
      .reset     (reset),
      .cmd       (ds_cmd),
      .operand_a (ds_a),
      .operand_b (ds_b),
      .done      (ds_done),
      .result    (ds_res)
   );

   // memories: one write and one registered read per array
   always_ff @(posedge clock) begin
      if (we_p) pos_mem[wa_pv] <= wd_p;
      if (we_v) vel_mem[wa_pv] <= wd_v;
      if (we_t) tim_mem[wa_t] <= wd_t;
      rd_p <= pos_mem[ra];
      rd_v <= vel_mem[ra];
      rd_t <= tim_mem[ra];
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(mul_a) * 64'(mul_b);
   end

   // speed, segment, prefix-sum and interpolation arithmetic
   always_comb begin
      two_ar       = prod_ff[63] ? '1 : {prod_ff[62:0], 1'b0};
      rad_sum      = {1'b0, sq_ff} + {1'b0, two_ar};
      rad          = rad_sum[64] ? '1 : rad_sum[63:0];
      root_clamped = (ds_res[31:0] > vmax_ff) ? vmax_ff : ds_res[31:0];
      case (phase_ff)
         PH_FRONT: seg_old = fvel_ff;
         PH_BACK:  seg_old = bvel_ff;
         default:  seg_old = fvel_ff;
      endcase
      seg_den   = (phase_ff == PH_JOIN) ? ({1'b0, bvel_ff} + {1'b0, fvel_ff})
                                        : ({1'b0, nvel_ff} + {1'b0, seg_old});
      fpos_next = fpos_ff + step_ff;
      bpos_next = bpos_ff - step_ff;
      psum      = {1'b0, sum_ff} + {1'b0, rd_t};
      key       = (act_ff == ACT_QUERY_TIME) ? rd_t : rd_p;
      kprev     = (act_ff == ACT_QUERY_TIME) ? prev_t_ff : prev_p_ff;
      if (!lsel_ff) begin
         y0 = prev_v_ff;
         y1 = cur_v_ff;
      end else if (act_ff == ACT_QUERY_TIME) begin
         y0 = prev_p_ff;
         y1 = cur_p_ff;
      end else begin
         y0 = prev_t_ff;
         y1 = cur_t_ff;
      end
      ydiff    = (y1 >= y0) ? (y1 - y0) : (y0 - y1);
      lerp_val = (y1 >= y0) ? (y0 + ds_res[31:0]) : (y0 - ds_res[31:0]);
   end

   // datapath steering
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      ds_cmd = '0;
      ds_a   = '0;
      ds_b   = '0;
      ra     = idx_ff[IDXW-1:0];
      we_p   = 1'b0;
      we_v   = 1'b0;
      we_t   = 1'b0;
      wa_pv  = nf_ff[IDXW-1:0];
      wa_t   = nf_ff[IDXW-1:0];
      wd_p   = '0;
      wd_v   = '0;
      wd_t   = '0;
      case (state_ff)
         S_G_FRONT0: begin
            we_p = 1'b1;
            we_v = 1'b1;
            we_t = 1'b1;
            wa_pv = '0;
            wa_t  = '0;
         end
         S_G_BACK0: begin
            we_p  = 1'b1;
            we_v  = 1'b1;
            wa_pv = top_idx('0);
            wd_p  = opnd_ff;
         end
         S_SP_MUL1: begin
            mul_a = (phase_ff == PH_BACK) ? bvel_ff : fvel_ff;
            mul_b = mul_a;
         end
         S_SP_MUL2: begin
            mul_a = (phase_ff == PH_BACK) ? dec_ff : acc_ff;
            mul_b = step_ff;
         end
         S_SP_ROOT: begin
            ds_cmd.start = 1'b1;
            ds_cmd.root  = 1'b1;
            ds_a         = rad;
         end
         S_SG_START: begin
            if (seg_den != '0) begin
               ds_cmd.start = 1'b1;
               ds_a         = {15'd0, step_ff, 17'd0};
               ds_b         = seg_den;
            end
         end
         S_G_STORE: begin
            case (phase_ff)
               PH_FRONT: begin
                  we_p = 1'b1;
                  we_v = 1'b1;
                  we_t = 1'b1;
                  wd_p = fpos_next;
                  wd_v = nvel_ff;
                  wd_t = seg_ff;
               end
               PH_BACK: begin
                  we_p  = 1'b1;
                  we_v  = 1'b1;
                  we_t  = 1'b1;
                  wa_pv = top_idx(nb_ff);
                  wa_t  = top_idx(nb_ff - CNTW'(1));
                  wd_p  = bpos_next;
                  wd_v  = nvel_ff;
                  wd_t  = seg_ff;
               end
               default: begin
                  we_t = 1'b1;
                  wa_t = top_idx(nb_ff - CNTW'(1));
                  wd_t = seg_ff;
               end
            endcase
         end
         S_CP_RD: begin
            ra = top_idx(nb_ff - CNTW'(1) - idx_ff);
         end
         S_CP_WR: begin
            we_p  = 1'b1;
            we_v  = 1'b1;
            we_t  = 1'b1;
            wa_pv = IDXW'(nf_ff + idx_ff);
            wa_t  = IDXW'(nf_ff + idx_ff);
            wd_p  = rd_p;
            wd_v  = rd_v;
            wd_t  = rd_t;
         end
         S_PF_WR: begin
            we_t = 1'b1;
            wa_t = idx_ff[IDXW-1:0];
            wd_t = psum[32] ? '1 : psum[31:0];
         end
         S_L_MUL: begin
            mul_a = ydiff;
            mul_b = lnum_ff;
         end
         S_L_DIV: begin
            ds_cmd.start = 1'b1;
            ds_a         = prod_ff;
            ds_b         = {1'b0, lden_ff};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_FRONT;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         vmax_ff      <= ONE_Q16;
         acc_ff       <= ONE_Q16;
         dec_ff       <= ONE_Q16;
         step_ff      <= MIN_STEP;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_MAX_VEL: vmax_ff <= csr_write_data;
               CSR_MAX_ACC: acc_ff  <= csr_write_data;
               CSR_MAX_DEC: dec_ff  <= csr_write_data;
               CSR_STEP:    step_ff <= (csr_write_data < MIN_STEP) ? MIN_STEP : csr_write_data;
               default: ;
            endcase
         end
         // S_DONE reloads the output register itself
         if (rsp_valid_ff && rsp_chan.ready && state_ff != S_DONE) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  act_ff    <= action_type'(req_chan.action);
                  opnd_ff   <= req_chan.operand_value;
                  res_t_ff  <= '0;
                  res_p_ff  <= '0;
                  res_v_ff  <= '0;
                  idx_ff    <= '0;
                  case (action_type'(req_chan.action))
                     ACT_GENERATE: begin
                        if (req_chan.operand_value <= step_ff) begin
                           count_ff  <= '0;
                           res_st_ff <= ST_SHORT;
                           state_ff  <= S_DONE;
                        end else begin
                           res_st_ff <= ST_OK;
                           state_ff  <= S_G_FRONT0;
                        end
                     end
                     ACT_QUERY_TIME, ACT_QUERY_DIST: begin
                        if (count_ff == '0) begin
                           res_st_ff <= ST_EMPTY;
                           state_ff  <= S_DONE;
                        end else begin
                           res_st_ff <= ST_OK;
                           state_ff  <= S_Q_RD;
                        end
                     end
                     default: begin
                        res_st_ff <= ST_OK;
                        state_ff  <= S_DONE;
                     end
                  endcase
               end
            end
            S_G_FRONT0: begin
               fpos_ff  <= '0;
               fvel_ff  <= '0;
               bpos_ff  <= opnd_ff;
               bvel_ff  <= '0;
               nf_ff    <= CNTW'(1);
               nb_ff    <= CNTW'(1);
               state_ff <= S_G_BACK0;
            end
            S_G_BACK0: state_ff <= S_G_TEST;
            S_G_TEST: begin
               if (!((bpos_ff - fpos_ff) > step_ff)) begin
                  phase_ff <= PH_JOIN;
                  state_ff <= S_SG_START;
               end else if ({1'b0, nf_ff} + {1'b0, nb_ff} >= {1'b0, MAXC}) begin
                  res_st_ff <= ST_FULL;
                  phase_ff  <= PH_JOIN;
                  state_ff  <= S_SG_START;
               end else begin
                  phase_ff <= PH_FRONT;
                  state_ff <= S_SP_MUL1;
               end
            end
            S_SP_MUL1: state_ff <= S_SP_MUL2;
            S_SP_MUL2: begin
               sq_ff    <= prod_ff;
               state_ff <= S_SP_ROOT;
            end
            S_SP_ROOT: state_ff <= S_SP_WAIT;
            S_SP_WAIT: begin
               if (ds_done) begin
                  nvel_ff  <= root_clamped;
                  state_ff <= S_SG_START;
               end
            end
            S_SG_START: begin
               if (seg_den == '0) begin
                  seg_ff   <= '1;
                  state_ff <= S_G_STORE;
               end else begin
                  state_ff <= S_SG_WAIT;
               end
            end
            S_SG_WAIT: begin
               if (ds_done) begin
                  seg_ff   <= (ds_res[63:32] != '0) ? '1 : ds_res[31:0];
                  state_ff <= S_G_STORE;
               end
            end
            S_G_STORE: begin
               case (phase_ff)
                  PH_FRONT: begin
                     fpos_ff <= fpos_next;
                     fvel_ff <= nvel_ff;
                     nf_ff   <= nf_ff + CNTW'(1);
                     if ((bpos_ff - fpos_next) < step_ff) begin
                        phase_ff <= PH_JOIN;
                        state_ff <= S_SG_START;
                     end else if ({1'b0, nf_ff} + {1'b0, nb_ff} + (CNTW+1)'(1)
                                  >= {1'b0, MAXC}) begin
                        res_st_ff <= ST_FULL;
                        phase_ff  <= PH_JOIN;
                        state_ff  <= S_SG_START;
                     end else begin
                        phase_ff <= PH_BACK;
                        state_ff <= S_SP_MUL1;
                     end
                  end
                  PH_BACK: begin
                     bpos_ff  <= bpos_next;
                     bvel_ff  <= nvel_ff;
                     nb_ff    <= nb_ff + CNTW'(1);
                     state_ff <= S_G_TEST;
                  end
                  default: begin
                     idx_ff   <= '0;
                     state_ff <= S_CP_RD;
                  end
               endcase
            end
            S_CP_RD: state_ff <= S_CP_WR;
            S_CP_WR: begin
               if (idx_ff + CNTW'(1) == nb_ff) begin
                  count_ff <= nf_ff + nb_ff;
                  idx_ff   <= CNTW'(1);
                  sum_ff   <= '0;
                  state_ff <= S_PF_RD;
               end else begin
                  idx_ff   <= idx_ff + CNTW'(1);
                  state_ff <= S_CP_RD;
               end
            end
            S_PF_RD: state_ff <= S_PF_WR;
            S_PF_WR: begin
               sum_ff <= psum[32] ? '1 : psum[31:0];
               if (idx_ff + CNTW'(1) == count_ff) begin
                  res_t_ff <= psum[32] ? '1 : psum[31:0];
                  res_p_ff <= opnd_ff;
                  res_v_ff <= '0;
                  state_ff <= S_DONE;
               end else begin
                  idx_ff   <= idx_ff + CNTW'(1);
                  state_ff <= S_PF_RD;
               end
            end
            S_Q_RD: state_ff <= S_Q_TEST;
            S_Q_TEST: begin
               if (key <= opnd_ff) begin
                  prev_t_ff <= rd_t;
                  prev_p_ff <= rd_p;
                  prev_v_ff <= rd_v;
                  if (idx_ff + CNTW'(1) == count_ff) begin
                     res_t_ff <= rd_t;
                     res_p_ff <= rd_p;
                     res_v_ff <= rd_v;
                     state_ff <= S_DONE;
                  end else begin
                     idx_ff   <= idx_ff + CNTW'(1);
                     state_ff <= S_Q_RD;
                  end
               end else if (idx_ff == '0) begin
                  res_t_ff <= rd_t;
                  res_p_ff <= rd_p;
                  res_v_ff <= rd_v;
                  state_ff <= S_DONE;
               end else begin
                  cur_t_ff <= rd_t;
                  cur_p_ff <= rd_p;
                  cur_v_ff <= rd_v;
                  lnum_ff  <= opnd_ff - kprev;
                  lden_ff  <= key - kprev;
                  lsel_ff  <= 1'b0;
                  state_ff <= S_L_MUL;
               end
            end
            S_L_MUL: state_ff <= S_L_DIV;
            S_L_DIV: state_ff <= S_L_WAIT;
            S_L_WAIT: begin
               if (ds_done) begin
                  if (!lsel_ff) begin
                     res_v_ff <= lerp_val;
                     lsel_ff  <= 1'b1;
                     state_ff <= S_L_MUL;
                  end else begin
                     if (act_ff == ACT_QUERY_TIME) begin
                        res_t_ff <= opnd_ff;
                        res_p_ff <= lerp_val;
                     end else begin
                        res_p_ff <= opnd_ff;
                        res_t_ff <= lerp_val;
                     end
                     state_ff <= S_DONE;
                  end
               end
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_t_ff     <= res_t_ff;
                  rsp_p_ff     <= res_p_ff;
                  rsp_v_ff     <= res_v_ff;
                  rsp_cnt_ff   <= 11'(count_ff);
                  rsp_st_ff    <= res_st_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_chan.ready          = (state_ff == S_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.point_time     = rsp_t_ff;
   assign rsp_chan.point_position = rsp_p_ff;
   assign rsp_chan.point_velocity = rsp_v_ff;
   assign rsp_chan.point_count    = rsp_cnt_ff;
   assign rsp_chan.status         = rsp_st_ff;
endmodule
